// File: sv/lookup3_byte_record_hash_macros.svh
// Assertion macros shared by the byte-serial lookup3 hash modules.
`ifndef LOOKUP3_BYTE_RECORD_HASH_MACROS_SVH
`define LOOKUP3_BYTE_RECORD_HASH_MACROS_SVH

// Same-cycle implication, sampled on clock and quiet while reset is high.
`define L3H_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and quiet while reset is high.
`define L3H_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/l3h_pkg.sv
// Package with the constants, types and mixing functions of the lookup3 record hash.
`timescale 1ns / 1ps

package l3h_pkg;

   // Seed of all three words and the block size in bytes.
   localparam logic [31:0] HASH_INIT    = 32'hdeadbeef;
   localparam int          BLOCK_BYTES  = 12;
   localparam logic [3:0]  LAST_POS     = 4'(BLOCK_BYTES - 1);

   // Round counts of the block mix and of the final mix.
   localparam int          MIX_ROUNDS   = 6;
   localparam int          FINAL_ROUNDS = 7;
   localparam logic [2:0]  MIX_DONE     = 3'(MIX_ROUNDS);

   // Finishing pipeline: mix rounds, one block add, final rounds.
   localparam int          PIPE_STAGES  = MIX_ROUNDS + 1 + FINAL_ROUNDS;
   localparam int          STAGE_W      = $clog2(PIPE_STAGES);

   // Width register.
   localparam int          HASH_BITS_W     = 7;
   localparam logic [6:0]  HASH_BITS_RESET = 7'd32;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } word3_type;

   localparam word3_type WORDS_INIT = '{a: HASH_INIT, b: HASH_INIT, c: HASH_INIT};

   // One finishing job: chaining words, pending block bytes and what to run.
   typedef struct packed {
      word3_type words;
      word3_type blk;
      logic      do_mix;
      logic      do_final;
   } job_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] k);
      return (x << k) | (x >> (6'd32 - {1'b0, k}));
   endfunction

   // One line of the block mix; idx selects the line.
   function automatic word3_type mix_round(input word3_type w, input logic [2:0] idx);
      word3_type r;
      r = w;
      case (idx)
         3'd0: begin
            r.a = (w.a - w.c) ^ rotl32(w.c, 5'd4);
            r.c = w.c + w.b;
         end
         3'd1: begin
            r.b = (w.b - w.a) ^ rotl32(w.a, 5'd6);
            r.a = w.a + w.c;
         end
         3'd2: begin
            r.c = (w.c - w.b) ^ rotl32(w.b, 5'd8);
            r.b = w.b + w.a;
         end
         3'd3: begin
            r.a = (w.a - w.c) ^ rotl32(w.c, 5'd16);
            r.c = w.c + w.b;
         end
         3'd4: begin
            r.b = (w.b - w.a) ^ rotl32(w.a, 5'd19);
            r.a = w.a + w.c;
         end
         3'd5: begin
            r.c = (w.c - w.b) ^ rotl32(w.b, 5'd4);
            r.b = w.b + w.a;
         end
         default: r = w;
      endcase
      return r;
   endfunction

   // One line of the final mix; idx selects the line.
   function automatic word3_type final_round(input word3_type w, input logic [2:0] idx);
      word3_type r;
      r = w;
      case (idx)
         3'd0: r.c = (w.c ^ w.b) - rotl32(w.b, 5'd14);
         3'd1: r.a = (w.a ^ w.c) - rotl32(w.c, 5'd11);
         3'd2: r.b = (w.b ^ w.a) - rotl32(w.a, 5'd25);
         3'd3: r.c = (w.c ^ w.b) - rotl32(w.b, 5'd16);
         3'd4: r.a = (w.a ^ w.c) - rotl32(w.c, 5'd4);
         3'd5: r.b = (w.b ^ w.a) - rotl32(w.a, 5'd14);
         3'd6: r.c = (w.c ^ w.b) - rotl32(w.b, 5'd24);
         default: r = w;
      endcase
      return r;
   endfunction

endpackage

// File: sv/l3h_chan_if.sv
// Valid/ready channel interfaces for the byte items and the hash items.
`timescale 1ns / 1ps

interface l3h_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   logic       empty_record;

   modport source (output valid, data_byte, last, empty_record, input ready);
   modport sink   (input valid, data_byte, last, empty_record, output ready);
endinterface

interface l3h_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

// File: sv/l3h_accum.sv
// Byte gathering, block chaining and background block mix of the record hash.
`timescale 1ns / 1ps

module l3h_accum
   import l3h_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   l3h_req_if.sink   req_chan,
   output job_type   job_o,
   output logic      job_valid_o,
   input  logic      job_ready_i
);

`include "lookup3_byte_record_hash_macros.svh"

   // Record state.
   word3_type  pre_ff, pre_in;
   word3_type  blk_ff, blk_in;
   logic [3:0] pos_ff, pos_in;
   logic       chained_ff, chained_in;
   logic       has_bytes_ff, has_bytes_in;

   // Background mixer.
   word3_type  mixed_ff, mixed_in;
   logic [2:0] mix_cnt_ff, mix_cnt_in;

   // Job register toward the finishing pipeline.
   job_type    job_ff, job_in;
   logic       job_valid_ff, job_valid_in;

   logic       take;
   logic       byte_take;
   logic       rec_end;
   logic       blk_end;
   logic [31:0] ins;
   word3_type  blk_next;
   word3_type  base;
   word3_type  new_pre;

   // A new item fits whenever the job register is free or drains now.
   assign req_chan.ready = !job_valid_ff || job_ready_i;
   assign job_o          = job_ff;
   assign job_valid_o    = job_valid_ff;

   // Byte placement and block-end sum.
   always_comb begin
      take      = req_chan.valid && req_chan.ready;
      byte_take = take && !req_chan.empty_record;
      rec_end   = take && req_chan.last;
      blk_end   = byte_take && !req_chan.last && (pos_ff == LAST_POS);
      ins       = {24'b0, req_chan.data_byte} << {pos_ff[1:0], 3'b000};
      blk_next  = blk_ff;
      if (byte_take) begin
         case (pos_ff[3:2])
            2'd0:    blk_next.a = blk_ff.a | ins;
            2'd1:    blk_next.b = blk_ff.b | ins;
            default: blk_next.c = blk_ff.c | ins;
         endcase
      end
      base      = chained_ff ? mixed_ff : pre_ff;
      new_pre.a = base.a + blk_next.a;
      new_pre.b = base.b + blk_next.b;
      new_pre.c = base.c + blk_next.c;
   end

   // Next record state: clear at record end, chain at a full block.
   always_comb begin
      pre_in       = pre_ff;
      blk_in       = blk_ff;
      pos_in       = pos_ff;
      chained_in   = chained_ff;
      has_bytes_in = has_bytes_ff;
      if (rec_end) begin
         pre_in       = WORDS_INIT;
         blk_in       = '0;
         pos_in       = '0;
         chained_in   = 1'b0;
         has_bytes_in = 1'b0;
      end else if (blk_end) begin
         pre_in       = new_pre;
         blk_in       = '0;
         pos_in       = '0;
         chained_in   = 1'b1;
         has_bytes_in = 1'b1;
      end else if (byte_take) begin
         blk_in       = blk_next;
         pos_in       = pos_ff + 4'd1;
         has_bytes_in = 1'b1;
      end
   end

   // Mixer runs one line per cycle after each full block.
   always_comb begin
      mixed_in   = mixed_ff;
      mix_cnt_in = mix_cnt_ff;
      if (blk_end) begin
         mixed_in   = new_pre;
         mix_cnt_in = '0;
      end else if (mix_cnt_ff != MIX_DONE) begin
         mixed_in   = mix_round(mixed_ff, mix_cnt_ff);
         mix_cnt_in = mix_cnt_ff + 3'd1;
      end
   end

   // The last item of a record hands a job to the finishing pipeline.
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff && !job_ready_i;
      if (rec_end) begin
         job_in.words    = pre_ff;
         job_in.blk      = blk_next;
         job_in.do_mix   = chained_ff && ((pos_ff != '0) || byte_take);
         job_in.do_final = has_bytes_ff || byte_take;
         job_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff       <= WORDS_INIT;
         blk_ff       <= '0;
         pos_ff       <= '0;
         chained_ff   <= 1'b0;
         has_bytes_ff <= 1'b0;
         mix_cnt_ff   <= MIX_DONE;
         job_valid_ff <= 1'b0;
      end else begin
         pre_ff       <= pre_in;
         blk_ff       <= blk_in;
         pos_ff       <= pos_in;
         chained_ff   <= chained_in;
         has_bytes_ff <= has_bytes_in;
         mix_cnt_ff   <= mix_cnt_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mixed_ff <= mixed_in;
      job_ff   <= job_in;
   end

   // The mixer must have finished before the next full block is chained.
   `L3H_ASSERT_IMP(a_mix_ready, blk_end && chained_ff, mix_cnt_ff == MIX_DONE, "mix not done at block end")
   // A full block restarts the mixer and the byte position.
   `L3H_ASSERT_NXT(a_block_restart, blk_end, (mix_cnt_ff == '0) && chained_ff && (pos_ff == '0), "block end not taken")
   // A record without bytes has neither a position nor a chained block.
   `L3H_ASSERT_IMP(a_empty_state, !has_bytes_ff, (pos_ff == '0) && !chained_ff, "empty record state broken")

endmodule

// File: sv/l3h_finish.sv
// Finishing pipeline: pending mix, last block add, final mix, width mask and result register.
`timescale 1ns / 1ps

module l3h_finish
   import l3h_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          job_i,
   input  logic             job_valid_i,
   output logic             job_ready_o,
   input  logic [6:0]       hash_bits_i,
   l3h_rsp_if.source        rsp_chan
);

`include "lookup3_byte_record_hash_macros.svh"

   job_type                  st_ff [PIPE_STAGES];
   job_type                  st_in [PIPE_STAGES];
   logic [PIPE_STAGES-1:0]   valid_ff, valid_in;
   logic [PIPE_STAGES-1:0]   load;
   logic [PIPE_STAGES:0]     space;
   logic                     out_valid_ff, out_valid_in;
   logic [63:0]              hash_ff, hash_in;
   logic                     out_load;
   logic [63:0]              mask;

   // Work of one stage: a mix line, the block add, or a final line.
   function automatic job_type stage_fn(input job_type s, input logic [STAGE_W-1:0] idx);
      job_type r;
      r = s;
      if (idx < STAGE_W'(MIX_ROUNDS)) begin
         if (s.do_mix) r.words = mix_round(s.words, idx[2:0]);
      end else if (idx == STAGE_W'(MIX_ROUNDS)) begin
         r.words.a = s.words.a + s.blk.a;
         r.words.b = s.words.b + s.blk.b;
         r.words.c = s.words.c + s.blk.c;
      end else begin
         if (s.do_final) r.words = final_round(s.words, 3'(idx - STAGE_W'(MIX_ROUNDS + 1)));
      end
      return r;
   endfunction

   // A stage has room when it is empty or its item moves on this cycle.
   always_comb begin
      space[PIPE_STAGES] = !out_valid_ff || rsp_chan.ready;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         space[k] = !valid_ff[k] || space[k+1];
      end
   end

   assign job_ready_o = space[0];

   // Stage loads and next values.
   always_comb begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (k == 0) begin
            load[k]  = job_valid_i && space[k];
            st_in[k] = stage_fn(job_i, STAGE_W'(k));
         end else begin
            load[k]  = valid_ff[k-1] && space[k];
            st_in[k] = stage_fn(st_ff[k-1], STAGE_W'(k));
         end
         valid_in[k] = load[k] || (valid_ff[k] && !space[k+1]);
      end
   end

   // Result register with the width mask; 64 and above keep every bit.
   always_comb begin
      mask         = hash_bits_i[6] ? {64{1'b1}} : ~({64{1'b1}} << hash_bits_i[5:0]);
      out_load     = valid_ff[PIPE_STAGES-1] && space[PIPE_STAGES];
      out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);
      hash_in      = out_load
                     ? ({st_ff[PIPE_STAGES-1].words.b, st_ff[PIPE_STAGES-1].words.c} & mask)
                     : hash_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (load[k]) st_ff[k] <= st_in[k];
      end
      hash_ff <= hash_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.hash_value = hash_ff;

   // A job taken from the gatherer lands in the first stage.
   `L3H_ASSERT_NXT(a_first_load, job_valid_i && job_ready_o, valid_ff[0], "job lost at pipe entry")
   // The last stage holds its item while the result register is blocked.
   `L3H_ASSERT_NXT(a_tail_hold, valid_ff[PIPE_STAGES-1] && !space[PIPE_STAGES], valid_ff[PIPE_STAGES-1] && $stable(st_ff[PIPE_STAGES-1]), "tail stage lost item")
   // Widths up to 32 leave the upper word clear.
   `L3H_ASSERT_IMP(a_narrow_mask, out_valid_ff && (hash_bits_i <= 7'd32), hash_ff[63:32] == '0, "upper word not masked")

endmodule

// File: sv/lookup3_byte_record_hash.sv
// Top level of the byte-serial lookup3 record hash with its width register.
`timescale 1ns / 1ps

// One byte item is accepted per clock cycle while the job register is free or
// draining, with no gaps at record or block boundaries. Bytes are gathered into a
// twelve-byte block buffer; at each full block the chaining words are summed and
// then mixed in the background, one mix line per cycle, which always completes
// before the next block can fill. The last item of a record hands its words to a
// fourteen-stage finishing pipeline (pending mix, block add, final mix) and a
// result register that applies the hash_bits mask; results come out at up to one
// per cycle. The pipeline collapses bubbles, so items keep flowing while a result
// waits to be taken. hash_bits resets to 32; the user must write it through
// csr_write_enable and csr_write_data only while no record is in flight, and
// the block itself does not enforce this.
module lookup3_byte_record_hash
   import l3h_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   l3h_req_if.sink                 req_chan,
   l3h_rsp_if.source               rsp_chan,
   input  logic                    csr_write_enable,
   input  logic [HASH_BITS_W-1:0]  csr_write_data
);

   logic [HASH_BITS_W-1:0] hash_bits_ff, hash_bits_in;
   job_type                job;
   logic                   job_valid;
   logic                   job_ready;

   // Width register.
   assign hash_bits_in = csr_write_enable ? csr_write_data : hash_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_bits_ff <= HASH_BITS_RESET;
      end else begin
         hash_bits_ff <= hash_bits_in;
      end
   end

   // Byte gathering and block chaining.
   l3h_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .job_o       (job),
      .job_valid_o (job_valid),
      .job_ready_i (job_ready)
   );

   // Final mix and result delivery.
   l3h_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .job_i       (job),
      .job_valid_i (job_valid),
      .job_ready_o (job_ready),
      .hash_bits_i (hash_bits_ff),
      .rsp_chan    (rsp_chan)
   );

endmodule

// File: dv/lookup3_byte_record_hash_tb.sv
// Self-checking testbench for the byte-serial lookup3 record hash.
`timescale 1ns / 1ps

module lookup3_byte_record_hash_tb
   import l3h_pkg::*;
();

   // Scoreboard: tracks the hash state of the open record and the queue of
   // hash items that the block still owes.
   class hash_scoreboard;
      bit [31:0] word_a;
      bit [31:0] word_b;
      bit [31:0] word_c;
      int unsigned block_fill;
      bit [HASH_BITS_W-1:0] width;
      bit [63:0] owed_hashes[$];
      int errors;
      int hashes_checked;
      int bytes_taken;
      int blocks_mixed;
      int ignored_items;

      function new();
         width = HASH_BITS_RESET;
         clear_words();
      endfunction

      function void clear_words();
         word_a = HASH_INIT;
         word_b = HASH_INIT;
         word_c = HASH_INIT;
         block_fill = 0;
      endfunction

      function bit [31:0] rol(bit [31:0] x, int k);
         return (x << k) | (x >> (32 - k));
      endfunction

      // Block mix, run when a byte arrives after a full block.
      function void mix_block();
         word_a -= word_c; word_a ^= rol(word_c, 4);  word_c += word_b;
         word_b -= word_a; word_b ^= rol(word_a, 6);  word_a += word_c;
         word_c -= word_b; word_c ^= rol(word_b, 8);  word_b += word_a;
         word_a -= word_c; word_a ^= rol(word_c, 16); word_c += word_b;
         word_b -= word_a; word_b ^= rol(word_a, 19); word_a += word_c;
         word_c -= word_b; word_c ^= rol(word_b, 4);  word_b += word_a;
         blocks_mixed++;
      endfunction

      // Final avalanche at the end of a nonempty record.
      function void final_mix();
         word_c ^= word_b; word_c -= rol(word_b, 14);
         word_a ^= word_c; word_a -= rol(word_c, 11);
         word_b ^= word_a; word_b -= rol(word_a, 25);
         word_c ^= word_b; word_c -= rol(word_b, 16);
         word_a ^= word_c; word_a -= rol(word_c, 4);
         word_b ^= word_a; word_b -= rol(word_a, 14);
         word_c ^= word_b; word_c -= rol(word_b, 24);
      endfunction

      // Widths above 64 behave as 64; zero keeps nothing.
      function bit [63:0] masked_hash();
         int unsigned kept;
         bit [63:0] full;
         kept = (width > 64) ? 64 : width;
         full = {word_b, word_c};
         if (kept == 0) return 64'd0;
         if (kept == 64) return full;
         return full & ((64'd1 << kept) - 64'd1);
      endfunction

      // Notes one accepted input item and queues the hash it produces, if any.
      function void note_item(bit [7:0] data_byte, bit last, bit empty_record);
         int unsigned pos;
         if (empty_record) begin
            if (!last) begin
               ignored_items++;
               return;
            end
            if (block_fill != 0) final_mix();
            owed_hashes.push_back(masked_hash());
            clear_words();
            return;
         end
         if (block_fill >= BLOCK_BYTES) begin
            mix_block();
            block_fill = 0;
         end
         pos = block_fill;
         if (pos < 4)
            word_a += {24'd0, data_byte} << ((pos % 4) * 8);
         else if (pos < 8)
            word_b += {24'd0, data_byte} << ((pos % 4) * 8);
         else
            word_c += {24'd0, data_byte} << ((pos % 4) * 8);
         block_fill = pos + 1;
         bytes_taken++;
         if (last) begin
            final_mix();
            owed_hashes.push_back(masked_hash());
            clear_words();
         end
      endfunction

      // Compares one accepted hash item with the oldest owed hash.
      function void check_hash(bit [63:0] actual);
         bit [63:0] expected;
         if (owed_hashes.size() == 0) begin
            $error("hash_value: unexpected item, actual %h", actual);
            errors++;
            return;
         end
         expected = owed_hashes.pop_front();
         hashes_checked++;
         if (actual !== expected) begin
            $error("hash_value mismatch: expected %h, actual %h", expected, actual);
            errors++;
         end
      endfunction

      function void check_drained();
         if (owed_hashes.size() != 0) begin
            $error("hash_value: %0d expected items never arrived", owed_hashes.size());
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [HASH_BITS_W-1:0] csr_write_data;

   l3h_req_if req_bus();
   l3h_rsp_if rsp_bus();

   hash_scoreboard board = new();

   int send_gap_max = 5;
   int recv_stall_max = 5;
   int hold_request = 0;
   int items_sent = 0;
   int widths_used = 0;

   lookup3_byte_record_hash dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Offers one item after a random gap and waits until it is taken.
   task automatic send_item(input bit [7:0] data_byte, input bit last, input bit empty_record);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= data_byte;
      req_bus.last         <= last;
      req_bus.empty_record <= empty_record;
      do @(posedge clock); while (!req_bus.ready);
      board.note_item(data_byte, last, empty_record);
      if (last || !empty_record) items_sent++;
   endtask

   // Sends a record of random bytes, with stray empty marks sprinkled in; the
   // record is closed by last on its final byte or by an empty mark.
   task automatic send_record(input int len, input bit close_empty);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         send_item(8'($urandom_range(0, 255)), (i == len - 1) && !close_empty, 1'b0);
      end
      if (len == 0 || close_empty) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
   endtask

   // Writes the width register once the block has drained.
   task automatic write_width(input bit [HASH_BITS_W-1:0] bits);
      while (board.owed_hashes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= bits;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.width = bits;
      widths_used++;
   endtask

   // Record lengths lean toward block boundaries and short records.
   task automatic send_random_record();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 8)       len = 0;
      else if (pick < 25) len = 12 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
      else if (pick < 90) len = $urandom_range(1, 30);
      else                len = $urandom_range(31, 60);
      send_record(len, (len > 0) && ($urandom_range(0, 4) == 0));
   endtask

   // Result side: random stalls per item, or one long hold when requested.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = $urandom_range(0, recv_stall_max);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         board.check_hash(rsp_bus.hash_value);
      end
   end

   // Main stimulus: directed records at the reset width, then random phases.
   initial begin
      bit [HASH_BITS_W-1:0] phase_widths[11];
      int phase_target;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.data_byte    <= 8'd0;
      req_bus.last         <= 1'b0;
      req_bus.empty_record <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_write_data       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty record on fresh state, then a stray empty mark.
      send_item(8'ha5, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);
      // One-byte records with the extreme byte values.
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      // Exactly one full block: final mix with no block mix before it.
      for (int i = 0; i < 12; i++) send_item((i % 2) ? 8'hff : 8'h00, i == 11, 1'b0);
      // Record closed by an empty mark, with a stray empty mark inside.
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'h7f, 1'b0, 1'b0);
      send_item(8'h3c, 1'b0, 1'b1);
      send_item(8'h01, 1'b0, 1'b0);
      send_item(8'hc3, 1'b1, 1'b1);
      req_bus.valid <= 1'b0;

      phase_widths = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd33, 7'd63, 7'd31, 7'd2, 7'd100, 7'd32,
                       7'($urandom_range(0, 127))};
      foreach (phase_widths[p]) begin
         write_width(phase_widths[p]);
         send_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 5;
         recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
         phase_target   = items_sent + 80;
         // Long output hold while one-byte records keep coming, so the
         // block fills up and pushes back on its input.
         if (p == 2) begin
            send_gap_max = 0;
            hold_request = 250;
            for (int i = 0; i < 60; i++) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end
         while (items_sent < phase_target) send_random_record();
         req_bus.valid <= 1'b0;
      end

      while (board.owed_hashes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      board.check_drained();
      $display("Checked %0d hashes over %0d record bytes with %0d block mixes.",
               board.hashes_checked, board.bytes_taken, board.blocks_mixed);
      $display("Used %0d width settings and skipped %0d stray empty marks.",
               widths_used, board.ignored_items);
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("Timeout waiting for the block.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
